// ===== hdl/lcd4_pkg.sv =====
// Shared types and constants of the 4-bit character LCD sequencer.
// Holds the word formats, the job descriptor between front and back, and the init table.
// No dependencies.
`default_nettype none

package lcd4_pkg;

  typedef enum logic [2:0] {
    OP_DATA   = 3'd0,
    OP_CMD    = 3'd1,
    OP_CURSOR = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_HOME   = 3'd4,
    OP_FLAG   = 3'd5,
    OP_GLYPH  = 3'd6,
    OP_INIT   = 3'd7
  } lcd4_op_e;

  typedef enum logic [1:0] {
    JOB_BYTE  = 2'd0,
    JOB_SLOW  = 2'd1,
    JOB_GLYPH = 2'd2,
    JOB_INIT  = 2'd3
  } lcd4_job_e;

  localparam logic [1:0] FLAG_DISPLAY = 2'd0;
  localparam logic [1:0] FLAG_CURSOR  = 2'd1;
  localparam logic [1:0] FLAG_BLINK   = 2'd2;

  localparam logic CFG_CMD_WAIT  = 1'b0;
  localparam logic CFG_SLOW_WAIT = 1'b1;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
  localparam logic [7:0] CMD_CGRAM_ADDR = 8'h40;
  localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] ROW1_OFFSET    = 8'h40;

  localparam logic [2:0]  FLAGS_RESET     = 3'b100;
  localparam logic [15:0] CMD_WAIT_RESET  = 16'd40;
  localparam logic [15:0] SLOW_WAIT_RESET = 16'd2000;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_BYTE  = 5'd1;
  localparam logic [STEP_W-1:0] LAST_SLOW  = 5'd2;
  localparam logic [STEP_W-1:0] LAST_GLYPH = 5'd17;
  localparam logic [STEP_W-1:0] LAST_INIT  = 5'd12;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  byte_value;
    logic [7:0]  column;
    logic [7:0]  line_index;
    logic [1:0]  flag_select;
    logic        flag_value;
    logic [7:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } lcd4_in_t;

  typedef struct packed {
    logic        register_select;
    logic [3:0]  bus_nibble;
    logic        enable_pulse;
    logic [15:0] wait_us;
    logic        last_step;
  } lcd4_out_t;

  // One classified operation waiting for the back end.
  typedef struct packed {
    lcd4_job_e   kind;
    logic        rs;
    logic [7:0]  cmd_byte;
    logic [63:0] rows;
  } lcd4_job_t;

  typedef struct packed {
    logic [15:0] cmd_wait;
    logic [15:0] slow_wait;
  } lcd4_cfg_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        en;
    logic        use_cmd_wait;
    logic [15:0] wait_us;
  } lcd4_init_step_t;

  // Power-up sequence: a long settle wait, the three function-set nibbles,
  // the switch to 4-bit mode, then four command bytes.
  function automatic lcd4_init_step_t init_step(logic [3:0] idx);
    lcd4_init_step_t s;
    s = '{nibble: 4'h0, en: 1'b0, use_cmd_wait: 1'b0, wait_us: 16'd0};
    unique case (idx)
      4'd0:  s = '{nibble: 4'h0, en: 1'b0, use_cmd_wait: 1'b0, wait_us: 16'd15000};
      4'd1:  s = '{nibble: 4'h3, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd5000};
      4'd2:  s = '{nibble: 4'h3, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd150};
      4'd3:  s = '{nibble: 4'h3, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd5000};
      4'd4:  s = '{nibble: 4'h2, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd40};
      4'd5:  s = '{nibble: 4'h2, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd0};
      4'd6:  s = '{nibble: 4'h8, en: 1'b1, use_cmd_wait: 1'b1, wait_us: 16'd0};
      4'd7:  s = '{nibble: 4'h0, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd0};
      4'd8:  s = '{nibble: 4'h8, en: 1'b1, use_cmd_wait: 1'b1, wait_us: 16'd0};
      4'd9:  s = '{nibble: 4'h0, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd0};
      4'd10: s = '{nibble: 4'hF, en: 1'b1, use_cmd_wait: 1'b1, wait_us: 16'd0};
      4'd11: s = '{nibble: 4'h0, en: 1'b1, use_cmd_wait: 1'b0, wait_us: 16'd0};
      4'd12: s = '{nibble: 4'h6, en: 1'b1, use_cmd_wait: 1'b1, wait_us: 16'd0};
      default: s = '{nibble: 4'h0, en: 1'b0, use_cmd_wait: 1'b0, wait_us: 16'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lcd4_front.sv =====
// Front end: accepts operation words, keeps the display flags, and turns each
// operation into a job descriptor for the queue. Depends on lcd4_pkg.
`default_nettype none

module lcd4_front #(
  parameter int unsigned COLUMNS = 16,
  parameter int unsigned ROWS    = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lcd4_pkg::lcd4_in_t in_data_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output lcd4_pkg::lcd4_job_t     job_o
);
  import lcd4_pkg::*;

  localparam logic [7:0] LastCol = 8'(COLUMNS - 1);

  logic [2:0] flags_q, flags_d;
  logic [7:0] col_clamped;
  logic       row_hi;
  lcd4_op_e   op;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign op         = lcd4_op_e'(in_data_i.opcode);

  assign col_clamped = (in_data_i.column >= 8'(COLUMNS)) ? LastCol : in_data_i.column;
  assign row_hi      = (ROWS > 1) && (in_data_i.line_index != 8'd0);

  always_comb begin
    flags_d = flags_q;
    if (op == OP_FLAG) begin
      unique case (in_data_i.flag_select)
        FLAG_DISPLAY: flags_d[2] = in_data_i.flag_value;
        FLAG_CURSOR:  flags_d[1] = in_data_i.flag_value;
        FLAG_BLINK:   flags_d[0] = in_data_i.flag_value;
        default:      flags_d = flags_q;
      endcase
    end
  end

  always_comb begin
    job_o.kind     = JOB_BYTE;
    job_o.rs       = 1'b0;
    job_o.cmd_byte = in_data_i.byte_value;
    job_o.rows     = in_data_i.glyph_rows;
    unique case (op)
      OP_DATA:   job_o.rs = 1'b1;
      OP_CMD:    job_o.rs = 1'b0;
      OP_CURSOR: job_o.cmd_byte = CMD_DDRAM_ADDR | (col_clamped + (row_hi ? ROW1_OFFSET : 8'd0));
      OP_CLEAR: begin
        job_o.kind     = JOB_SLOW;
        job_o.cmd_byte = CMD_CLEAR;
      end
      OP_HOME: begin
        job_o.kind     = JOB_SLOW;
        job_o.cmd_byte = CMD_HOME;
      end
      OP_FLAG:   job_o.cmd_byte = CMD_DISP_CTRL | {5'd0, flags_d};
      OP_GLYPH: begin
        job_o.kind     = JOB_GLYPH;
        job_o.cmd_byte = CMD_CGRAM_ADDR | {2'd0, in_data_i.glyph_slot[2:0], 3'd0};
      end
      OP_INIT:   job_o.kind = JOB_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FLAGS_RESET;
    end else if (push_o) begin
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcd4_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on lcd4_pkg for the job descriptor.
`default_nettype none

module lcd4_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire lcd4_pkg::lcd4_job_t push_job_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     head_valid_o,
  output lcd4_pkg::lcd4_job_t      head_job_o
);
  import lcd4_pkg::*;

  lcd4_job_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcd4_back.sv =====
// Back end: walks the head job one pin step per cycle, unless stalled, into the
// output register. Depends on lcd4_pkg for the job, step and config types.
`default_nettype none

module lcd4_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lcd4_pkg::lcd4_cfg_t cfg_i,
  input  wire logic                head_valid_i,
  input  wire lcd4_pkg::lcd4_job_t head_job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lcd4_pkg::lcd4_out_t      out_data_o
);
  import lcd4_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  lcd4_out_t         out_q, out_d;
  lcd4_out_t         step_word;
  logic              advance;
  logic              is_last;
  logic [STEP_W-1:0] last_idx;
  logic [3:0]        byte_idx;
  logic [2:0]        row_idx;
  logic [7:0]        row_byte;
  logic [7:0]        cur_byte;
  logic              cur_rs;
  lcd4_init_step_t   init_word;

  assign advance  = !out_valid_q || out_ready_i;
  assign byte_idx = step_q[4:1];
  assign row_idx  = 3'(byte_idx - 4'd1);
  assign row_byte = head_job_i.rows[{row_idx, 3'b000} +: 8];
  assign init_word = init_step(step_q[3:0]);

  always_comb begin
    unique case (head_job_i.kind)
      JOB_BYTE:  last_idx = LAST_BYTE;
      JOB_SLOW:  last_idx = LAST_SLOW;
      JOB_GLYPH: last_idx = LAST_GLYPH;
      JOB_INIT:  last_idx = LAST_INIT;
    endcase
  end
  assign is_last = (step_q == last_idx);

  // A glyph starts with its address command, then sends row bytes as data.
  always_comb begin
    if (head_job_i.kind == JOB_GLYPH && byte_idx != 4'd0) begin
      cur_byte = row_byte;
      cur_rs   = 1'b1;
    end else begin
      cur_byte = head_job_i.cmd_byte;
      cur_rs   = head_job_i.rs;
    end
  end

  always_comb begin
    step_word.last_step = is_last;
    if (head_job_i.kind == JOB_INIT) begin
      step_word.register_select = 1'b0;
      step_word.bus_nibble      = init_word.nibble;
      step_word.enable_pulse    = init_word.en;
      step_word.wait_us         = init_word.use_cmd_wait ? cfg_i.cmd_wait : init_word.wait_us;
    end else if (head_job_i.kind == JOB_SLOW && step_q == LAST_SLOW) begin
      step_word.register_select = 1'b0;
      step_word.bus_nibble      = 4'h0;
      step_word.enable_pulse    = 1'b0;
      step_word.wait_us         = cfg_i.slow_wait;
    end else begin
      step_word.register_select = cur_rs;
      step_word.bus_nibble      = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      step_word.enable_pulse    = 1'b1;
      step_word.wait_us         = step_q[0] ? cfg_i.cmd_wait : 16'd0;
    end
  end

  assign pop_o = advance && head_valid_i && is_last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_d  = step_word;
        step_d = is_last ? '0 : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/char_lcd_4bit_sequencer_unit.sv =====
// An accepted word is queued, then its first step is written into the output register.
// Throughput: one pin step per cycle from the back-end step counter while the output is
// not stalled; an operation is 2 to 18 steps (byte 2, clear/home 3, init 13, glyph 18).
// The two-entry job queue lets new words in while earlier ones are still being stepped.
// Reset (rst_ni low, asynchronous) empties the queue and output register, restores the
// display flags to display on, and the waits to 40 us and 2000 us.
`default_nettype none

module char_lcd_4bit_sequencer_unit #(
  parameter int unsigned COLUMNS = 16,
  parameter int unsigned ROWS    = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lcd4_pkg::lcd4_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lcd4_pkg::lcd4_out_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [15:0]         cfg_wdata_i
);
  import lcd4_pkg::*;

  // Wait registers. They are to be written by the user only while the block is idle,
  // so the back end can read them directly while stepping; the block does not enforce it.
  lcd4_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cmd_wait  <= CMD_WAIT_RESET;
      cfg_q.slow_wait <= SLOW_WAIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CMD_WAIT:  cfg_q.cmd_wait  <= cfg_wdata_i;
        CFG_SLOW_WAIT: cfg_q.slow_wait <= cfg_wdata_i;
      endcase
    end
  end

  logic      push;
  logic      q_full;
  lcd4_job_t push_job;
  logic      pop;
  logic      head_valid;
  lcd4_job_t head_job;

  // The front end classifies each accepted word into a job and updates the
  // display flags at acceptance, so flag changes apply in word order.
  lcd4_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // The queue decouples acceptance from stepping.
  lcd4_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // The back end emits the head job one step per cycle while the output is not stalled,
  // and retires it on its last step.
  lcd4_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
